### hw/rtl/seu_pkg.sv
package seu_pkg;

    localparam int unsigned CODE_W = 21;

    localparam logic [CODE_W-1:0] CODE_MAX  = 21'h10FFFF;
    localparam logic [CODE_W-1:0] ACC_SAT   = 21'h1FFFFF;
    localparam logic [CODE_W-1:0] LIM_1BYTE = 21'h00007F;
    localparam logic [CODE_W-1:0] LIM_2BYTE = 21'h0007FF;
    localparam logic [CODE_W-1:0] LIM_3BYTE = 21'h00FFFF;

    localparam logic [7:0] LEAD_2BYTE = 8'hC0;
    localparam logic [7:0] LEAD_3BYTE = 8'hE0;
    localparam logic [7:0] LEAD_4BYTE = 8'hF0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // result word, as seen on the master side
    typedef struct packed {
        logic       err;
        logic [7:0] data;
    } res_word_t;

    // hex digit decode: valid flag and 4-bit value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

### hw/rtl/string_escape_unescaper_utf8.sv
// String literal unescaper with UTF-8 output.
//
// Slave side: one content byte per word on s_tdata, s_tlast on the final
// byte of the literal. Prefix and closing quote are stripped upstream.
// Master side: decoded bytes on m_tdata; m_tlast marks the last byte caused
// by one input word; m_tuser flags a unicode escape with no valid hex code
// (that word carries data 0 and m_tlast).
//
// Throughput: one input word per cycle while each word yields at most one
// byte and the receiver does not stall. A closing brace of a unicode escape
// yields up to four bytes, which leave the result buffer one per cycle while
// the receiver takes them; the next word loads only as the last one leaves.
// A one-word holding register sits in front of the decoder, so s_tready
// is a register output and a word is still taken while a result waits.
// When the receiver stalls, the buffer holds its bytes, the holding
// register fills and s_tready drops.
// Reset (aresetn low, synchronous) returns to normal text mode, empties the
// result buffer and the holding register. Escape state is also cleared
// after each word flagged with s_tlast.
module string_escape_unescaper_utf8 (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] escape_error
);
    import seu_pkg::*;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_SKIP = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    // scan state
    mode_t              mode_reg, mode_next;
    logic [CODE_W-1:0]  accum_reg, accum_next;
    logic               big_reg, big_next;
    logic               seen_reg, seen_next;
    logic               bad_reg, bad_next;

    // holding register in front of the decoder
    logic               hold_vld_reg;
    logic [7:0]         hold_byte_reg;
    logic               hold_last_reg;

    // result buffer, head in entry 0
    logic [7:0]         buf_reg [4];
    logic [2:0]         cnt_reg;
    logic               err_reg;

    // decoder input
    logic               src_vld;
    logic [7:0]         src_byte;
    logic               src_last;
    logic               can_load, load, pop, take;

    // decoder output
    logic [2:0]         n_res;
    logic [7:0]         res_byte [4];
    logic               res_err;

    logic [4:0]         hex;
    logic [CODE_W+3:0]  shifted;
    res_word_t          head;

    assign src_vld  = hold_vld_reg | s_tvalid;
    assign src_byte = hold_vld_reg ? hold_byte_reg : s_tdata;
    assign src_last = hold_vld_reg ? hold_last_reg : s_tlast;

    assign pop      = m_tvalid & m_tready;
    assign can_load = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);
    assign load     = src_vld & can_load;
    assign take     = s_tvalid & s_tready;

    assign hex     = hex_decode(src_byte);
    assign shifted = {accum_reg, hex[3:0]};

    always_comb begin
        mode_next   = mode_reg;
        accum_next  = accum_reg;
        big_next    = big_reg;
        seen_next   = seen_reg;
        bad_next    = bad_reg;
        n_res       = 3'd0;
        res_err     = 1'b0;
        res_byte[0] = src_byte;
        res_byte[1] = 8'd0;
        res_byte[2] = 8'd0;
        res_byte[3] = 8'd0;

        case (mode_reg)
            MODE_TEXT: begin
                if (src_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    n_res = 3'd1;
                end
            end
            MODE_ESC: begin
                mode_next = MODE_TEXT;
                if (src_byte == CH_N) begin
                    n_res = 3'd1; res_byte[0] = CH_LF;
                end else if (src_byte == CH_T) begin
                    n_res = 3'd1; res_byte[0] = CH_TAB;
                end else if (src_byte == CH_R) begin
                    n_res = 3'd1; res_byte[0] = CH_CR;
                end else if (src_byte == CH_BSLASH || src_byte == CH_SQUOTE ||
                             src_byte == CH_DQUOTE) begin
                    n_res = 3'd1;
                end else if (src_byte == CH_U) begin
                    mode_next = MODE_SKIP;
                end
            end
            MODE_SKIP: begin
                if (src_byte == CH_LBRACE) begin
                    mode_next  = MODE_HEX;
                    accum_next = '0;
                    big_next   = 1'b0;
                    seen_next  = 1'b0;
                    bad_next   = 1'b0;
                end
            end
            MODE_HEX: begin
                if (src_byte == CH_RBRACE) begin
                    mode_next = MODE_TEXT;
                    if (!seen_reg || bad_reg) begin
                        // empty or malformed code: one error word
                        n_res       = 3'd1;
                        res_byte[0] = 8'd0;
                        res_err     = 1'b1;
                    end else if (big_reg || accum_reg > CODE_MAX) begin
                        n_res = 3'd0;
                    end else if (accum_reg <= LIM_1BYTE) begin
                        n_res       = 3'd1;
                        res_byte[0] = accum_reg[7:0];
                    end else if (accum_reg <= LIM_2BYTE) begin
                        n_res       = 3'd2;
                        res_byte[0] = LEAD_2BYTE | {3'd0, accum_reg[10:6]};
                        res_byte[1] = CONT_BYTE | {2'd0, accum_reg[5:0]};
                    end else if (accum_reg <= LIM_3BYTE) begin
                        n_res       = 3'd3;
                        res_byte[0] = LEAD_3BYTE | {4'd0, accum_reg[15:12]};
                        res_byte[1] = CONT_BYTE | {2'd0, accum_reg[11:6]};
                        res_byte[2] = CONT_BYTE | {2'd0, accum_reg[5:0]};
                    end else begin
                        n_res       = 3'd4;
                        res_byte[0] = LEAD_4BYTE | {5'd0, accum_reg[20:18]};
                        res_byte[1] = CONT_BYTE | {2'd0, accum_reg[17:12]};
                        res_byte[2] = CONT_BYTE | {2'd0, accum_reg[11:6]};
                        res_byte[3] = CONT_BYTE | {2'd0, accum_reg[5:0]};
                    end
                end else if (!hex[4]) begin
                    bad_next = 1'b1;
                end else begin
                    seen_next = 1'b1;
                    if (!big_reg) begin
                        // saturate once past the top code point
                        if (shifted > {4'd0, CODE_MAX}) begin
                            big_next   = 1'b1;
                            accum_next = ACC_SAT;
                        end else begin
                            accum_next = shifted[CODE_W-1:0];
                        end
                    end
                end
            end
            default: begin
                mode_next = MODE_TEXT;
            end
        endcase

        if (src_last) begin
            mode_next  = MODE_TEXT;
            accum_next = '0;
            big_next   = 1'b0;
            seen_next  = 1'b0;
            bad_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_TEXT;
            accum_reg    <= '0;
            big_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            bad_reg      <= 1'b0;
            hold_vld_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            err_reg      <= 1'b0;
        end else begin
            // holding register: fills when a word arrives that cannot load
            if (hold_vld_reg) begin
                if (load) begin
                    hold_vld_reg <= 1'b0;
                end
            end else if (take && !can_load) begin
                hold_vld_reg <= 1'b1;
            end

            if (load) begin
                mode_reg  <= mode_next;
                accum_reg <= accum_next;
                big_reg   <= big_next;
                seen_reg  <= seen_next;
                bad_reg   <= bad_next;
                cnt_reg   <= n_res;
                err_reg   <= res_err;
            end else if (pop) begin
                cnt_reg   <= cnt_reg - 3'd1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (take && !hold_vld_reg && !can_load) begin
            hold_byte_reg <= s_tdata;
            hold_last_reg <= s_tlast;
        end
        if (load) begin
            for (int i = 0; i < 4; i++) begin
                buf_reg[i] <= res_byte[i];
            end
        end else if (pop) begin
            for (int i = 0; i < 3; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[3] <= 8'd0;
        end
    end

    assign head.data = buf_reg[0];
    assign head.err  = err_reg;

    assign s_tready = ~hold_vld_reg;
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = head.data;
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tuser  = head.err;

endmodule

### hw/rtl/seu_checker.sv
module seu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // stalled result word holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("result word changed under stall");

    // error word is a lone zero byte closing its run
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("malformed error word");

    // reset empties the result buffer and opens the input
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not idle after reset");

    // no input word taken and nothing pending: output cannot start
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result word without input");

endmodule

bind string_escape_unescaper_utf8 seu_checker u_seu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

### test/tb_string_escape_unescaper_utf8.sv
`timescale 1ns / 100ps

module tb_string_escape_unescaper_utf8;

    import seu_pkg::*;

    // decoder scan state, mirrors the block's escape tracking
    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_SKIP,
        SCAN_HEX
    } scan_t;

    // one input word waiting to be offered
    typedef struct {
        logic [7:0] text;
        logic       fin;
    } text_word_t;

    // one decoded word expected on the master side
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       err;
    } decoded_word_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] text_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // run_last
    logic       m_tuser;            // [0] escape_error

    string_escape_unescaper_utf8 DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // queues: words still to send, decoded words still owed by the block
    text_word_t    text_queue[$];
    decoded_word_t decoded_queue[$];

    int  fail_count = 0;
    int  words_out  = 0;
    int  cycle_no   = 0;
    bit  quiet      = 1'b0;   // no new gaps or random stalls begin while set
    bit  took       = 1'b0;   // slave word taken at the last rising edge
    bit  rx_holding = 1'b0;   // receiver in its long hold-off

    // shadow decoder state
    scan_t             scan_q    = SCAN_TEXT;
    logic [CODE_W-1:0] accum_q   = '0;
    logic              big_q     = 1'b0;
    logic              digit_q   = 1'b0;
    logic              bad_q     = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // reset released on a falling edge
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // hard limit, well above the slowest legal run
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // quiet stretches: redrawn periodically, one chance in four of no idling
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no % 64 == 0) begin
            quiet <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(12, 30);
    endfunction

    // hex digit: bit 4 = valid, bits 3:0 = value
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        case (c) inside
            ["0":"9"]: return {1'b1, c[3:0]};
            ["a":"f"],
            ["A":"F"]: return {1'b1, 4'(c[3:0] + 4'd9)};
            default:   return 5'd0;
        endcase
    endfunction

    // Expected decode of one accepted word: walks the shadow state and
    // queues 0..4 result words, m_tlast on the final one.
    task automatic decode_text_word(input logic [7:0] c, input logic fin);
        logic [7:0]        b[4];
        logic              e;
        int                n;
        logic [4:0]        hv;
        logic [CODE_W+3:0] wide;
        logic [CODE_W-1:0] cp;
        decoded_word_t     w;
        n = 0;
        e = 1'b0;
        case (scan_q)
            SCAN_TEXT: begin
                if (c == CH_BSLASH) begin
                    scan_q = SCAN_ESC;
                end else begin
                    b[0] = c;
                    n = 1;
                end
            end
            SCAN_ESC: begin
                scan_q = SCAN_TEXT;
                if (c == CH_N) begin
                    b[0] = CH_LF;
                    n = 1;
                end else if (c == CH_T) begin
                    b[0] = CH_TAB;
                    n = 1;
                end else if (c == CH_R) begin
                    b[0] = CH_CR;
                    n = 1;
                end else if (c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE) begin
                    b[0] = c;
                    n = 1;
                end else if (c == CH_U) begin
                    scan_q = SCAN_SKIP;
                end
                // any other escape letter is swallowed
            end
            SCAN_SKIP: begin
                if (c == CH_LBRACE) begin
                    scan_q  = SCAN_HEX;
                    accum_q = '0;
                    big_q   = 1'b0;
                    digit_q = 1'b0;
                    bad_q   = 1'b0;
                end
            end
            SCAN_HEX: begin
                if (c == CH_RBRACE) begin
                    scan_q = SCAN_TEXT;
                    cp = accum_q;
                    if (!digit_q || bad_q) begin
                        // empty or non-hex code: single error word, beats too big
                        b[0] = 8'h00;
                        e = 1'b1;
                        n = 1;
                    end else if (!big_q && cp <= CODE_MAX) begin
                        if (cp <= LIM_1BYTE) begin
                            b[0] = cp[7:0];
                            n = 1;
                        end else if (cp <= LIM_2BYTE) begin
                            b[0] = LEAD_2BYTE | {3'b000, cp[10:6]};
                            b[1] = CONT_BYTE | {2'b00, cp[5:0]};
                            n = 2;
                        end else if (cp <= LIM_3BYTE) begin
                            b[0] = LEAD_3BYTE | {4'b0000, cp[15:12]};
                            b[1] = CONT_BYTE | {2'b00, cp[11:6]};
                            b[2] = CONT_BYTE | {2'b00, cp[5:0]};
                            n = 3;
                        end else begin
                            b[0] = LEAD_4BYTE | {5'b00000, cp[20:18]};
                            b[1] = CONT_BYTE | {2'b00, cp[17:12]};
                            b[2] = CONT_BYTE | {2'b00, cp[11:6]};
                            b[3] = CONT_BYTE | {2'b00, cp[5:0]};
                            n = 4;
                        end
                    end
                    // above the code space: nothing, no error
                end else begin
                    hv = nibble_of(c);
                    if (!hv[4]) begin
                        bad_q = 1'b1;
                    end else begin
                        digit_q = 1'b1;
                        if (!big_q) begin
                            wide = {accum_q, hv[3:0]};
                            if (wide > CODE_MAX) begin
                                // saturate and freeze
                                big_q   = 1'b1;
                                accum_q = ACC_SAT;
                            end else begin
                                accum_q = wide[CODE_W-1:0];
                            end
                        end
                    end
                end
            end
        endcase
        // end of literal drops any half-done escape
        if (fin) begin
            scan_q  = SCAN_TEXT;
            accum_q = '0;
            big_q   = 1'b0;
            digit_q = 1'b0;
            bad_q   = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            w.data = b[i];
            w.last = (i == n - 1);
            w.err  = e;
            decoded_queue.push_back(w);
        end
    endtask

    // Scoreboard at the rising edge: check the result word first, then
    // decode the slave word taken at this same edge.
    always @(posedge aclk) begin
        decoded_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_out <= words_out + 1;
            if (decoded_queue.size() == 0) begin
                report_mismatch("unexpected word, data", m_tdata, 0);
            end else begin
                want = decoded_queue.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch("m_tdata", m_tdata, want.data);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("m_tlast", m_tlast, want.last);
                end
                if (m_tuser !== want.err) begin
                    report_mismatch("m_tuser", m_tuser, want.err);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            decode_text_word(s_tdata, s_tlast);
        end
        took <= aresetn && s_tvalid && s_tready;
    end

    // Sender: moves on only once the current word has been taken; a gap
    // may follow each word. During the receiver hold-off it keeps offering.
    int gap_left = 0;
    always @(negedge aclk) begin
        text_word_t nxt;
        if (aresetn && (!s_tvalid || took)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (text_queue.size() > 0) begin
                nxt = text_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.text;
                s_tlast  <= nxt.fin;
                if (!quiet && !rx_holding && $urandom_range(0, 3) == 0) begin
                    gap_left = idle_len();
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the result
    // buffer and holding register fill and s_tready drops.
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rx_holding = (hold_left > 0);
            m_tready <= 1'b0;
        end else if (!hold_done && words_out >= 40) begin
            hold_done  = 1'b1;
            hold_left  = 80;
            rx_holding = 1'b1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = idle_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---- stimulus building ----

    task automatic put_text(input logic [7:0] c, input logic fin = 1'b0);
        text_word_t w;
        w.text = c;
        w.fin  = fin;
        text_queue.push_back(w);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(v - 4'd10);
    endfunction

    // byte that is neither a hex digit nor a closing brace
    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) begin
            return CH_LBRACE;
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (nibble_of(c) != 5'd0 || c == CH_RBRACE);
        return c;
    endfunction

    // digits of v, shortest form plus up to two leading zeros
    task automatic add_hex_digits(ref logic [7:0] lit[$], input logic [CODE_W-1:0] v);
        int nd;
        nd = 1;
        while (nd < 6 && (v >> (4 * nd)) != 0) begin
            nd++;
        end
        nd += $urandom_range(0, 2);
        for (int i = nd - 1; i >= 0; i--) begin
            lit.push_back(hex_char(4'(v >> (4 * i)), $urandom_range(0, 1)));
        end
    endtask

    // one unicode escape with a random body
    task automatic add_unicode(ref logic [7:0] lit[$]);
        int         k;
        int         nj;
        logic [7:0] c;
        lit.push_back(CH_BSLASH);
        lit.push_back(CH_U);
        // junk before the brace is skipped
        nj = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < nj; i++) begin
            c = 8'($urandom_range(0, 255));
            lit.push_back((c == CH_LBRACE) ? CH_N : c);
        end
        lit.push_back(CH_LBRACE);
        k = $urandom_range(0, 9);
        case (k)
            0: ;   // empty code
            1: begin
                add_hex_digits(lit, 21'($urandom_range(0, 'hFFF)));
                lit.insert($urandom_range(lit.size() - 1, lit.size()), non_hex_byte());
            end
            2, 3: add_hex_digits(lit, 21'($urandom_range(0, 'h7F)));
            4:    add_hex_digits(lit, 21'($urandom_range('h80, 'h7FF)));
            5, 6: add_hex_digits(lit, 21'($urandom_range('h800, 'hFFFF)));
            7:    add_hex_digits(lit, 21'($urandom_range('h10000, 'h10FFFF)));
            8:    add_hex_digits(lit, 21'($urandom_range('h110000, 'h1FFFFF)));
            default: begin
                // accumulator overflow: long run of digits
                lit.push_back(hex_char(4'($urandom_range(1, 15)), $urandom_range(0, 1)));
                repeat ($urandom_range(6, 8)) begin
                    lit.push_back(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1)));
                end
            end
        endcase
        lit.push_back(CH_RBRACE);
    endtask

    // a random literal; sometimes cut short, possibly in the middle of an escape
    task automatic add_literal();
        logic [7:0] lit[$];
        logic [7:0] simple[7];
        int         len;
        simple = '{CH_N, CH_T, CH_R, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, 8'h00};
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: lit.push_back(8'($urandom_range(0, 255)));
                3, 4: begin
                    simple[6] = 8'($urandom_range(0, 255));
                    lit.push_back(CH_BSLASH);
                    lit.push_back(simple[$urandom_range(0, 6)]);
                end
                default: add_unicode(lit);
            endcase
        end
        len = lit.size();
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, len);
        end
        for (int i = 0; i < len; i++) begin
            put_text(lit[i], i == len - 1);
        end
    endtask

    initial begin
        // directed: byte extremes, a plain escape, a swallowed escape,
        // empty code, the top code point, and a literal ending mid-escape
        put_text(8'h00);
        put_text(8'hFF, 1'b1);
        put_text(CH_BSLASH);
        put_text(CH_N);
        put_text(CH_BSLASH);
        put_text(CH_DQUOTE);
        put_text(CH_BSLASH);
        put_text("q");
        put_text(CH_BSLASH);
        put_text(CH_U);
        put_text(CH_LBRACE);
        put_text(CH_RBRACE);
        put_text(CH_BSLASH);
        put_text(CH_U);
        put_text(CH_LBRACE);
        put_text("1");
        put_text("0");
        put_text("F");
        put_text("f");
        put_text("F");
        put_text("f");
        put_text(CH_RBRACE);
        put_text(CH_BSLASH, 1'b1);

        // random literals, until at least 145 words are queued
        while (text_queue.size() < 145) begin
            add_literal();
        end

        // drain: all words sent, every decoded word seen, then settle
        @(posedge aresetn);
        while (text_queue.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (decoded_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        while (decoded_queue.size() != 0) begin
            report_mismatch("missing word, data", 0, decoded_queue[0].data);
            void'(decoded_queue.pop_front());
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
